@@ rtl/core/bfrm_pkg.sv @@
// ----------------------------------------------------------------------------
// bfrm_pkg: shared types and constants of the running-mean window
// Field widths, the command record and the command codes that pass from
// the front queue to the back-end sequencer.
// ----------------------------------------------------------------------------
package bfrm_pkg;

  localparam int DATA_W        = 8;
  localparam int OCC_W         = 3;
  localparam int DEPTH_DEFAULT = 5;
  localparam int CMDQ_DEPTH    = 2;

  // command codes carried in the kind field
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] sample;
  } cmd_t;

endpackage

@@ rtl/core/bfrm_ram.sv @@
// ----------------------------------------------------------------------------
// bfrm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module bfrm_ram #(
  parameter int WIDTH = bfrm_pkg::DATA_W,
  parameter int DEPTH = bfrm_pkg::DEPTH_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/bfrm_div.sv @@
// ----------------------------------------------------------------------------
// bfrm_div: restoring divider, one quotient bit per cycle
// Divides a DVD_W-bit dividend by a DVS_W-bit divisor.
// ----------------------------------------------------------------------------
module bfrm_div #(
  parameter int DVD_W = 11,
  parameter int DVS_W = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int SW = $clog2(DVD_W + 1);

  logic             busy;
  logic [SW-1:0]    steps;
  logic [DVD_W-1:0] acc;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  assign rem_sh   = {rem, acc[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(DVD_W);
      end else if (busy) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift quotient bits into the dividend register as it empties
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[DVD_W-2:0], fits};
      rem <= fits ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    end
  end

endmodule

@@ rtl/core/bfrm_front.sv @@
// ----------------------------------------------------------------------------
// bfrm_front: input side command queue
// Accepts items, tags them as insert or remove and holds them for the back.
// ----------------------------------------------------------------------------
module bfrm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              kind,
  input  logic [bfrm_pkg::DATA_W-1:0]       sample_value,
  output logic                              cmd_valid,
  output bfrm_pkg::cmd_t                    cmd,
  input  logic                              cmd_pop
);

  localparam int PW = $clog2(bfrm_pkg::CMDQ_DEPTH);
  localparam int NW = $clog2(bfrm_pkg::CMDQ_DEPTH + 1);

  bfrm_pkg::cmd_t slots [bfrm_pkg::CMDQ_DEPTH];
  bfrm_pkg::cmd_t incoming;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [NW-1:0]  fill;
  logic           do_push;
  logic           do_pop;

  assign full      = fill == NW'(bfrm_pkg::CMDQ_DEPTH);
  assign cmd_valid = fill != '0;
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // drop the sample of a remove so the back sees a clean record
  always_comb begin
    incoming.kind   = kind;
    incoming.sample = (kind == bfrm_pkg::KIND_INSERT) ? sample_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + NW'(1);
        2'b01:   fill <= fill - NW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

@@ rtl/core/bfrm_back.sv @@
// ----------------------------------------------------------------------------
// bfrm_back: window sequencer
// Updates the window, running total and count, and runs the mean division.
// ----------------------------------------------------------------------------
module bfrm_back #(
  parameter int DEPTH = bfrm_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  input  bfrm_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  output logic                              res_valid,
  input  logic                              res_pop,
  output logic [bfrm_pkg::DATA_W-1:0]       mean_ceiling,
  output logic [bfrm_pkg::DATA_W-1:0]       removed_value,
  output logic                              empty_error,
  output logic [bfrm_pkg::OCC_W-1:0]        occupancy
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = bfrm_pkg::DATA_W + CW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_PREP  = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]                  state;
  bfrm_pkg::cmd_t              cur;
  logic [IW-1:0]               oldest;
  logic [CW-1:0]               count;
  logic [TW-1:0]               total;

  logic                        is_insert;
  logic                        drop;
  logic [IW-1:0]               oldest_next;
  logic [CW-1:0]               count_next;
  logic [TW-1:0]               total_next;
  logic [IW:0]                 slot_sum;
  logic [IW-1:0]               wr_slot;
  logic [bfrm_pkg::DATA_W-1:0] rd_data;
  logic                        div_start;
  logic                        div_done;
  logic [TW-1:0]               quotient;

  assign cmd_pop   = (state == S_IDLE) && cmd_valid && !res_valid;
  assign is_insert = cur.kind == bfrm_pkg::KIND_INSERT;
  assign div_start = state == S_PREP;

  // an insert into a full window and a remove from a non-empty one both
  // drop the oldest value
  always_comb begin
    drop        = is_insert ? (count == CW'(DEPTH)) : (count != '0);
    oldest_next = oldest;
    count_next  = count;
    total_next  = total;
    if (drop) begin
      oldest_next = (oldest == IW'(DEPTH - 1)) ? '0 : oldest + IW'(1);
      count_next  = count - CW'(1);
      total_next  = total - TW'(rd_data);
    end
    slot_sum = (IW + 1)'(oldest_next) + (IW + 1)'(count_next);
    wr_slot  = (slot_sum >= (IW + 1)'(DEPTH)) ? IW'(slot_sum - (IW + 1)'(DEPTH))
                                              : slot_sum[IW-1:0];
  end

  bfrm_ram #(
    .WIDTH (bfrm_pkg::DATA_W),
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_window (
    .clk     (clk),
    .wr_en   ((state == S_APPLY) && is_insert),
    .wr_addr (wr_slot),
    .wr_data (cur.sample),
    .rd_en   (cmd_pop),
    .rd_addr (oldest),
    .rd_data (rd_data)
  );

  bfrm_div #(
    .DVD_W (TW),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total + TW'(count) - TW'(1)),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      total     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_pop && res_valid) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (is_insert) begin
            oldest <= oldest_next;
            count  <= count_next + CW'(1);
            total  <= total_next + TW'(cur.sample);
            state  <= S_PREP;
          end else begin
            oldest    <= oldest_next;
            count     <= count_next;
            total     <= total_next;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_PREP: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_pop) begin
      cur <= cmd;
    end
    if (state == S_APPLY && !is_insert) begin
      mean_ceiling  <= '0;
      removed_value <= drop ? rd_data : '0;
      empty_error   <= !drop;
      occupancy     <= bfrm_pkg::OCC_W'(count_next);
    end else if (state == S_DIV && div_done) begin
      mean_ceiling  <= bfrm_pkg::DATA_W'(quotient);
      removed_value <= '0;
      empty_error   <= 1'b0;
      occupancy     <= bfrm_pkg::OCC_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("window count beyond depth");

  a_empty_total: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (total == '0))
    else $error("running total non-zero on empty window");

  a_pop_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == S_APPLY) && !res_valid)
    else $error("command taken while a result was pending");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

endmodule

@@ rtl/core/bounded_fifo_running_mean.sv @@
// ----------------------------------------------------------------------------
// bounded_fifo_running_mean: sliding window with ceiling running mean
// Holds up to DEPTH 8-bit values in first-in first-out order and answers
// each insert with the rounded-up mean and each remove with the oldest value.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: present kind and sample_value, raise push; the
//   item transfers on a clock edge with push high and full low. kind 0
//   inserts sample_value (dropping the oldest value first if the window is
//   full); kind 1 removes the oldest value.
//   Result side is a queue too: while empty is low the result of the oldest
//   item sits on mean_ceiling, removed_value, empty_error and occupancy; it
//   transfers on an edge with pop high and empty low. One result per item.
//   A remove from an empty window gives empty_error high and no change.
// Flow:
//   From the back end taking a command, an insert's result waits on the
//   restoring divider, which yields one quotient bit per cycle; a remove's
//   result is registered in the apply state from the registered window
//   read. Each item is registered in the command queue before the back end
//   can take it. The back end holds new work until the result transfers,
//   so it takes no new command while a result waits. A two-entry command
//   queue keeps accepting items while a result waits, until it is full.
// Reset:
//   rst (synchronous) empties the window, command queue and result register;
//   window RAM is not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
module bounded_fifo_running_mean #(
  parameter int DEPTH = bfrm_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        kind,
  input  logic [bfrm_pkg::DATA_W-1:0] sample_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [bfrm_pkg::DATA_W-1:0] mean_ceiling,
  output logic [bfrm_pkg::DATA_W-1:0] removed_value,
  output logic                        empty_error,
  output logic [bfrm_pkg::OCC_W-1:0]  occupancy
);

  logic           cmd_valid;
  bfrm_pkg::cmd_t cmd;
  logic           cmd_pop;
  logic           res_valid;

  // front: take items and queue them as commands
  bfrm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .kind         (kind),
    .sample_value (sample_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // back: advance the window and produce one result per command
  bfrm_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .res_valid     (res_valid),
    .res_pop       (pop),
    .mean_ceiling  (mean_ceiling),
    .removed_value (removed_value),
    .empty_error   (empty_error),
    .occupancy     (occupancy)
  );

  assign empty = !res_valid;

endmodule
